[rtl/core/scpl_pkg.sv]
// Shared constants, types and PLRU helper functions for the snooping tag store.
`timescale 1ns / 1ps

package scpl_pkg;

  // Cache geometry
  localparam int SET_COUNT  = 128;
  localparam int LINE_BYTES = 32;
  localparam int WAY_COUNT  = 8;

  localparam int ADDR_W = 32;
  localparam int OFS_W  = $clog2(LINE_BYTES);
  localparam int SET_W  = $clog2(SET_COUNT);
  localparam int TAG_W  = ADDR_W - OFS_W - SET_W;
  localparam int WAY_W  = $clog2(WAY_COUNT);
  localparam int PLRU_W = WAY_COUNT - 1;
  localparam int CNT_W  = WAY_W + 1;
  localparam int LINE_COUNT = SET_COUNT * WAY_COUNT;

  // Field widths on the ports
  localparam int REQ_W   = 2;
  localparam int OWNER_W = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_OWN_ID = 1'b0;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_CPU_RD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CPU_WR   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SNOOP_RD = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SNOOP_WR = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } scpl_state_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             bus_rdx_request;
    logic             invalidated;
  } scpl_result_t;

  // Walk the tree away from the most recently used side.
  function automatic logic [WAY_W-1:0] plru_victim(input logic [PLRU_W-1:0] bits);
    logic [WAY_W-1:0] v;
    if (!bits[0]) begin
      if (!bits[1]) v = bits[3] ? 3'd1 : 3'd0;
      else          v = bits[4] ? 3'd3 : 3'd2;
    end else begin
      if (!bits[2]) v = bits[5] ? 3'd5 : 3'd4;
      else          v = bits[6] ? 3'd7 : 3'd6;
    end
    return v;
  endfunction

  // Point the tree bits along the path to the given way away from it.
  function automatic logic [PLRU_W-1:0] plru_touch(input logic [PLRU_W-1:0] bits,
                                                   input logic [WAY_W-1:0] w);
    logic [PLRU_W-1:0] b;
    case (w)
      3'd0:    b = bits | 7'h0B;
      3'd1:    b = (bits | 7'h03) & 7'h77;
      3'd2:    b = (bits | 7'h11) & 7'h7D;
      3'd3:    b = (bits | 7'h01) & 7'h6D;
      3'd4:    b = (bits | 7'h24) & 7'h7E;
      3'd5:    b = (bits | 7'h04) & 7'h5E;
      3'd6:    b = (bits | 7'h40) & 7'h7A;
      default: b = bits & 7'h3A;
    endcase
    return b;
  endfunction

  // Lowest set bit of a way mask.
  function automatic logic [WAY_W-1:0] first_way(input logic [WAY_COUNT-1:0] mask);
    logic [WAY_W-1:0] f;
    f = '0;
    for (int i = WAY_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) f = WAY_W'(i);
    end
    return f;
  endfunction

endpackage

[rtl/core/scpl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module scpl_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/scpl_cfg.sv]
// APB-style configuration register holding the cache's own identifier.
`timescale 1ns / 1ps

module scpl_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scpl_pkg::CFG_AW-1:0] paddr,
  input  logic [scpl_pkg::CFG_DW-1:0] pwdata,
  output logic [scpl_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output logic [scpl_pkg::OWNER_W-1:0] own_id
);
  import scpl_pkg::*;

  logic [OWNER_W-1:0] own_id_r;
  logic [OWNER_W-1:0] own_id_nxt;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_OWN_ID);

  always_comb begin
    own_id_nxt = own_id_r;
    if (wr_en) own_id_nxt = pwdata[OWNER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= '0;
    end else begin
      own_id_r <= own_id_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_OWN_ID) prdata = CFG_DW'(own_id_r);
  end

  assign own_id = own_id_r;

endmodule

[rtl/core/scpl_seq.sv]
// Sequencer, shared tag comparator and tag/valid/PLRU memories.
`timescale 1ns / 1ps

module scpl_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [scpl_pkg::REQ_W-1:0]    req_type,
  input  logic [scpl_pkg::ADDR_W-1:0]   address,
  input  logic [scpl_pkg::OWNER_W-1:0]  bus_owner,
  input  logic [scpl_pkg::OWNER_W-1:0]  own_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output scpl_pkg::scpl_result_t        out_result
);
  import scpl_pkg::*;

  scpl_state_t state_r, state_nxt;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SET_W-1:0]     clr_r, clr_nxt;
  logic [REQ_W-1:0]     req_r;
  logic [SET_W-1:0]     set_r;
  logic [TAG_W-1:0]     tag_r;
  logic                 own_r;
  logic [WAY_COUNT-1:0] match_r;
  logic [WAY_COUNT-1:0] vrow_r;
  logic [PLRU_W-1:0]    plru_r;
  scpl_result_t         out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 accept;
  logic                 advance;
  logic                 last_cmp;
  logic [WAY_W-1:0]     cmp_way;
  logic                 cmp_hit;

  logic [TAG_W-1:0]     tag_rd;
  logic [WAY_COUNT-1:0] vrow_rd;
  logic [PLRU_W-1:0]    plru_rd;

  logic                      tag_we;
  logic [SET_W+WAY_W-1:0]    tag_waddr;
  logic [SET_W+WAY_W-1:0]    tag_raddr;
  logic                      row_we;
  logic                      vrow_we;
  logic                      plru_we;
  logic [SET_W-1:0]          row_addr;
  logic [WAY_COUNT-1:0]      vrow_wdata;
  logic [PLRU_W-1:0]         plru_wdata;

  logic                 found;
  logic [WAY_W-1:0]     hit_way;
  logic [WAY_W-1:0]     victim;
  logic [WAY_W-1:0]     use_way;
  logic                 is_cpu;

  assign accept   = in_valid && in_ready;
  assign advance  = !out_valid_r || out_ready;
  assign last_cmp = (cnt_r == CNT_W'(WAY_COUNT));
  assign cmp_way  = WAY_W'(cnt_r - CNT_W'(1));
  assign cmp_hit  = vrow_rd[cmp_way] && (tag_rd == tag_r);

  assign found   = |match_r;
  assign hit_way = first_way(match_r);
  assign victim  = plru_victim(plru_r);
  assign use_way = found ? hit_way : victim;
  assign is_cpu  = (req_r == REQ_CPU_RD) || (req_r == REQ_CPU_WR);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == SET_W'(SET_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (((req_type == REQ_SNOOP_RD) || (req_type == REQ_SNOOP_WR)) &&
              (bus_owner == own_id)) begin
            state_nxt = ST_UPDATE;
          end else begin
            state_nxt = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (last_cmp) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (advance) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    in_ready      = 1'b0;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    tag_we        = 1'b0;
    vrow_we       = 1'b0;
    plru_we       = 1'b0;
    vrow_wdata    = vrow_r;
    plru_wdata    = plru_r;
    row_addr      = set_r;
    case (state_r)
      ST_CLEAR: begin
        vrow_we    = 1'b1;
        plru_we    = 1'b1;
        vrow_wdata = '0;
        plru_wdata = '0;
        row_addr   = clr_r;
        clr_nxt    = clr_r + SET_W'(1);
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
      end
      ST_LOOKUP: begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_UPDATE: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          if (!own_r) begin
            if (is_cpu) begin
              out_nxt.hit             = found;
              out_nxt.way             = use_way;
              out_nxt.bus_rdx_request = !found && (req_r == REQ_CPU_WR);
              tag_we     = !found;
              vrow_we    = !found;
              vrow_wdata = vrow_r | (WAY_COUNT'(1) << use_way);
              plru_we    = 1'b1;
              plru_wdata = plru_touch(plru_r, use_way);
            end else begin
              out_nxt.hit = found;
              out_nxt.way = hit_way;
              if (req_r == REQ_SNOOP_WR) begin
                out_nxt.invalidated = found;
                vrow_we    = found;
                vrow_wdata = vrow_r & ~match_r;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign row_we    = vrow_we;
  assign tag_raddr = {set_r, cnt_r[WAY_W-1:0]};
  assign tag_waddr = {set_r, victim};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture and compare accumulation
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      req_r   <= req_type;
      set_r   <= address[OFS_W +: SET_W];
      tag_r   <= address[ADDR_W-1 -: TAG_W];
      own_r   <= ((req_type == REQ_SNOOP_RD) || (req_type == REQ_SNOOP_WR)) &&
                 (bus_owner == own_id);
      match_r <= '0;
    end else if ((state_r == ST_LOOKUP) && (cnt_r != '0)) begin
      match_r[cmp_way] <= cmp_hit;
    end
    if ((state_r == ST_LOOKUP) && last_cmp) begin
      vrow_r <= vrow_rd;
      plru_r <= plru_rd;
    end
  end

  scpl_ram #(.DATA_W(TAG_W), .DEPTH(LINE_COUNT)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_r),
    .raddr (tag_raddr),
    .rdata (tag_rd)
  );

  scpl_ram #(.DATA_W(WAY_COUNT), .DEPTH(SET_COUNT)) u_valid_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_addr),
    .wdata (vrow_wdata),
    .raddr (set_r),
    .rdata (vrow_rd)
  );

  scpl_ram #(.DATA_W(PLRU_W), .DEPTH(SET_COUNT)) u_plru_ram (
    .clk   (clk),
    .we    (plru_we),
    .waddr (row_addr),
    .wdata (plru_wdata),
    .raddr (set_r),
    .rdata (plru_rd)
  );

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

[rtl/core/snooping_cache_tag_plru_unit.sv]
// Top level of the snooping 8-way tag store with tree pseudo-LRU replacement.
`timescale 1ns / 1ps
//
// Tag store for an 8-way set-associative cache with write-invalidate snooping.
// Input stream: one transfer per request (cpu read/write, snooped read/write).
//   The request kind travels in in_tuser; address and bus owner in in_tdata.
// Output stream: one transfer per request carrying hit, way, bus read-exclusive
//   request and invalidate flags.
// Config port: APB-style, one register (own cache id) at byte address 0.
//   Snoops from this owner change nothing and return an all-zero result.
// Lookup: a request walks the eight ways through one tag comparator, one way
//   per cycle, behind the registered read of the tag RAM, then takes an update
//   step; a snoop from the own cache skips the lookup. A new request is taken
//   only once the last one has left its update step.
// Reset: after rst_n the block sweeps the valid and PLRU memories, one set per
//   cycle, through all SET_COUNT (128) sets before in_tready rises. Config writes
//   are taken during the sweep.
// Stall: the result sits in an output register; the next request is accepted
//   while it waits, and its update step holds until the register drains.
module snooping_cache_tag_plru_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] address, [34:32] bus_owner, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] hit, [3:1] way, [4] bus_rdx_request,
                                  // [5] invalidated, [7:6] zero
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import scpl_pkg::*;

  logic [OWNER_W-1:0] own_id;
  scpl_result_t       result;

  // Hold the cache id written over the configuration port
  scpl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .own_id  (own_id)
  );

  // Lookup, replace and invalidate under the sequencer
  scpl_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .req_type   (in_tuser[REQ_W-1:0]),
    .address    (in_tdata[ADDR_W-1:0]),
    .bus_owner  (in_tdata[ADDR_W +: OWNER_W]),
    .own_id     (own_id),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  // Pack result fields, lowest field first
  assign out_tdata = {2'b00, result.invalidated, result.bus_rdx_request,
                      result.way, result.hit};

endmodule

[sim/scpl_checker.sv]
`timescale 1ns / 1ps
// Checker that mirrors the tag store and compares every result transfer.
module scpl_tag_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [scpl_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [scpl_pkg::REQ_W-1:0]       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [scpl_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic                             cfg_pready,
  input  logic [scpl_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [scpl_pkg::CFG_DW-1:0]      cfg_pwdata,
  output int                               fail_count,
  output int                               pending
);
  import scpl_pkg::*;

  logic [TAG_W-1:0]   tag_mem   [LINE_COUNT];
  logic               line_live [LINE_COUNT];
  logic [PLRU_W-1:0]  tree_bits [SET_COUNT];
  logic [OWNER_W-1:0] own_id;
  scpl_result_t       lookups_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Follow the tree bits away from the side used last.
  function automatic logic [WAY_W-1:0] pick_victim(input logic [PLRU_W-1:0] t);
    if (!t[0]) return t[1] ? {2'b01, t[4]} : {2'b00, t[3]};
    return t[2] ? {2'b11, t[6]} : {2'b10, t[5]};
  endfunction

  // Point root, half and pair bits away from the way just used.
  function automatic logic [PLRU_W-1:0] touch_tree(input logic [PLRU_W-1:0] t,
                                                   input logic [WAY_W-1:0] w);
    logic [PLRU_W-1:0] n;
    n = t;
    n[0] = ~w[2];
    if (!w[2]) n[1] = ~w[1];
    else       n[2] = ~w[1];
    n[3 + int'(w[2:1])] = ~w[0];
    return n;
  endfunction

  function automatic scpl_result_t resolve_request(input logic [REQ_W-1:0]   req,
                                                   input logic [ADDR_W-1:0]  addr,
                                                   input logic [OWNER_W-1:0] owner);
    scpl_result_t     r;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
    int               base;
    logic             snoop;
    r       = '0;
    set_idx = addr[OFS_W +: SET_W];
    tag     = addr[ADDR_W-1 -: TAG_W];
    base    = int'(set_idx) * WAY_COUNT;
    snoop   = (req == REQ_SNOOP_RD) || (req == REQ_SNOOP_WR);
    if (snoop && owner == own_id) return r;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (line_live[base + w] && tag_mem[base + w] == tag) begin
        if (!r.hit) begin
          r.hit = 1'b1;
          r.way = WAY_W'(w);
        end
        if (req == REQ_SNOOP_WR) begin
          line_live[base + w] = 1'b0;
          r.invalidated       = 1'b1;
        end
      end
    end
    if (!snoop) begin
      if (!r.hit) begin
        r.way                   = pick_victim(tree_bits[set_idx]);
        tag_mem[base + r.way]   = tag;
        line_live[base + r.way] = 1'b1;
        r.bus_rdx_request       = (req == REQ_CPU_WR);
      end
      tree_bits[set_idx] = touch_tree(tree_bits[set_idx], r.way);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    scpl_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINE_COUNT; i++) begin
        tag_mem[i]   = '1;
        line_live[i] = 1'b0;
      end
      for (int s = 0; s < SET_COUNT; s++) tree_bits[s] = '0;
      own_id = '0;
      lookups_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {REG_OWN_ID, 2'b00})
        own_id = cfg_pwdata[OWNER_W-1:0];
      // Older requests drain before the one accepted at this edge joins.
      if (out_tvalid && out_tready) begin
        if (lookups_due.size() == 0) begin
          $error("result transfer with no request waiting");
          fail_count++;
        end else begin
          want = lookups_due.pop_front();
          check_field("hit", want.hit, out_tdata[0]);
          check_field("way", want.way, out_tdata[3:1]);
          check_field("bus_rdx_request", want.bus_rdx_request, out_tdata[4]);
          check_field("invalidated", want.invalidated, out_tdata[5]);
        end
      end
      if (in_tvalid && in_tready)
        lookups_due.push_back(resolve_request(in_tuser, in_tdata[ADDR_W-1:0],
                                              in_tdata[ADDR_W +: OWNER_W]));
    end
    pending = lookups_due.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Top of the tag store testbench: stimulus, flow control and verdict.
module tb;
  import scpl_pkg::*;

  // Slowest run is roughly 750 requests plus gaps and stalls, behind the
  // clearing sweep; the limit leaves a wide margin.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 80;
  localparam int HOLD_AFTER    = 250;
  localparam int PHASE_ITEMS   = 175;
  localparam int QUIET_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 24;
  localparam int TAG_POOL      = 12;
  localparam int SET_POOL      = 4;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [31:0] address, [34:32] bus_owner, rest zero
  logic [REQ_W-1:0]      in_tuser;   // [1:0] req_type
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [0] hit, [3:1] way, [4] bus_rdx_request,
                                     // [5] invalidated, [7:6] zero
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_AW-1:0]     cfg_paddr;
  logic [CFG_DW-1:0]     cfg_pwdata;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending;
  int sent_count;
  int cycle_count;
  bit quiet;   // set for the tail of the run: no gaps, no stalls

  always #5 clk = ~clk;

  snooping_cache_tag_plru_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  scpl_tag_checker i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Offer one request; return at the rising edge where the transfer happens.
  // An optional burst of idle cycles comes first unless the run is quiet.
  task automatic send_req(input logic [REQ_W-1:0]   req,
                          input logic [ADDR_W-1:0]  addr,
                          input logic [OWNER_W-1:0] owner);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - ADDR_W - OWNER_W){1'b0}}, owner, addr};
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // Drop valid, hold off until every result is back, then settle for a margin.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // edge where pready is seen high with penable.
  task automatic write_own_id(input logic [OWNER_W-1:0] id);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_OWN_ID, 2'b00};
    cfg_pwdata  <= CFG_DW'(id);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_W-1:0] tag,
                                                  input logic [SET_W-1:0] set_idx);
    return {tag, set_idx, {OFS_W{1'b0}}};
  endfunction

  // Result side: mostly ready, with short stall bursts, and once a long
  // hold-off so the block fills up and pushes back on the input.
  initial begin : receiver
    int span;
    bit held;
    out_tready = 1'b0;
    held       = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && sent_count >= HOLD_AFTER) begin
        out_tready <= 1'b0;
        span = HOLD_CYCLES;
        held = 1'b1;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        span = 1;
      end else begin
        out_tready <= 1'b0;
        span = $urandom_range(1, 5);
      end
      repeat (span) @(negedge clk);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [TAG_W-1:0]   tag_pool [TAG_POOL];
    logic [SET_W-1:0]   set_pool [SET_POOL];
    logic [OWNER_W-1:0] phase_id [4];
    logic [REQ_W-1:0]   req;
    logic [ADDR_W-1:0]  addr;
    logic [OWNER_W-1:0] owner;
    int                 pick;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_CPU_RD;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    quiet       = 1'b0;
    sent_count  = 0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // The block takes register writes during its clearing sweep.
    write_own_id(3'd2);

    // Directed: fill, hit, both address extremes, own-cache snoops,
    // snoop invalidate, snoop misses, then a full set plus one to force
    // the tree victim onto a valid way.
    send_req(REQ_CPU_RD, 32'h0000_0000, 3'd0);
    send_req(REQ_CPU_RD, 32'h0000_001F, 3'd7);
    send_req(REQ_CPU_WR, 32'hFFFF_FFFF, 3'd0);
    send_req(REQ_CPU_WR, 32'hFFFF_FFE0, 3'd5);
    send_req(REQ_SNOOP_RD, 32'h0000_0000, 3'd7);
    send_req(REQ_SNOOP_RD, 32'h0000_0000, 3'd2);   // own snoop: all zero
    send_req(REQ_SNOOP_WR, 32'hFFFF_FFFF, 3'd2);   // own snoop: no invalidate
    send_req(REQ_CPU_RD, 32'hFFFF_FFFF, 3'd0);
    send_req(REQ_SNOOP_WR, 32'h0000_0000, 3'd0);
    send_req(REQ_SNOOP_RD, 32'h0000_0000, 3'd1);
    send_req(REQ_SNOOP_WR, 32'h0000_0000, 3'd3);
    send_req(REQ_CPU_RD, 32'h0000_0000, 3'd4);
    for (int t = 1; t <= WAY_COUNT + 1; t++)
      send_req((t % 2 == 0) ? REQ_CPU_WR : REQ_CPU_RD,
               line_addr(TAG_W'(t), SET_W'(5)), OWNER_W'(t));
    send_req(REQ_CPU_RD, line_addr(TAG_W'(1), SET_W'(5)), 3'd6);
    send_req(REQ_SNOOP_WR, line_addr(TAG_W'(WAY_COUNT + 1), SET_W'(5)), 3'd7);

    // Small pools of tags and sets so that lookups hit, evict and get
    // snooped often; the pool holds the all-zero and all-one tags.
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < TAG_POOL; i++) tag_pool[i] = TAG_W'($urandom);
    set_pool[0] = '0;
    set_pool[1] = '1;
    set_pool[2] = SET_W'($urandom);
    set_pool[3] = SET_W'($urandom);

    phase_id[0] = 3'd7;
    phase_id[1] = 3'd0;
    phase_id[2] = OWNER_W'($urandom_range(1, 6));
    phase_id[3] = 3'd7;

    for (int p = 0; p < 4; p++) begin
      drain();
      write_own_id(phase_id[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k >= PHASE_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        pick  = $urandom_range(0, 99);
        owner = OWNER_W'($urandom_range(0, 7));
        if (pick < 10) begin
          // noise: any kind, any address
          req  = REQ_W'($urandom_range(0, 3));
          addr = $urandom;
        end else begin
          if (pick < 45)      req = REQ_CPU_RD;
          else if (pick < 70) req = REQ_CPU_WR;
          else if (pick < 85) req = REQ_SNOOP_RD;
          else                req = REQ_SNOOP_WR;
          addr = {tag_pool[$urandom_range(0, TAG_POOL - 1)],
                  set_pool[$urandom_range(0, SET_POOL - 1)], OFS_W'($urandom)};
        end
        send_req(req, addr, owner);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
